// ===== design/tsmr_pkg.sv =====
// Shared constants, types and helper functions of the tensor sum and mean reduction block.
package tsmr_pkg;

	// Sizes of the tensor and of the arithmetic.
	localparam int MAX_COLS     = 64;
	localparam int MAX_ROWS     = 1024;
	localparam int MAX_CHANNELS = 1024;
	localparam int SAMPLE_BITS  = 16;
	localparam int ACC_BITS     = 48;

	// Widths of the configured counts and of the position counters.
	localparam int CNT_BITS    = 11;
	localparam int COLCNT_BITS = 7;
	localparam int ROW_BITS    = 10;
	localparam int COL_BITS    = $clog2(MAX_COLS);
	localparam int CH_BITS     = 10;

	// Divisor widths: rows times columns, and rows times columns times channels.
	localparam int RC_BITS  = 17;
	localparam int DIV_BITS = 27;

	// Configuration port.
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 11;
	localparam logic [CFG_IDX_BITS-1:0] REG_MODE          = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_REDUCE_OP     = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_ROW_COUNT     = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_COL_COUNT     = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_CHANNEL_COUNT = 3'd4;

	// Reduction modes and operations.
	localparam logic [1:0] MODE_PASS   = 2'd0;
	localparam logic [1:0] MODE_TENSOR = 2'd1;
	localparam logic [1:0] MODE_CHAN   = 2'd2;
	localparam logic [1:0] MODE_COL    = 2'd3;
	localparam logic       SUM         = 1'b0;
	localparam logic       MEAN        = 1'b1;

	localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
	localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

	// One result as it leaves the block.
	typedef struct packed {
		logic signed [ACC_BITS-1:0] value;
		logic [CH_BITS-1:0]         channel_index;
		logic [COL_BITS-1:0]        column_index;
		logic                       last;
	} result_t;

	// Request to and response from the iterative divider.
	typedef struct packed {
		logic                       start;
		logic signed [ACC_BITS-1:0] dividend;
		logic [DIV_BITS-1:0]        divisor;
	} div_req_t;

	typedef struct packed {
		logic                       busy;
		logic                       done;
		logic signed [ACC_BITS-1:0] quotient;
	} div_rsp_t;

	// Adds a sample to an accumulator, clamping to the accumulator range.
	function automatic logic signed [ACC_BITS-1:0] sat_add(
		input logic signed [ACC_BITS-1:0]    a,
		input logic signed [SAMPLE_BITS-1:0] b
	);
		logic signed [ACC_BITS:0] s;
		s = (ACC_BITS+1)'(a) + (ACC_BITS+1)'(b);
		if (s[ACC_BITS] != s[ACC_BITS-1]) begin
			return s[ACC_BITS] ? ACC_MIN : ACC_MAX;
		end
		return s[ACC_BITS-1:0];
	endfunction

	// A count of zero acts as one, a count above the limit acts as the limit.
	function automatic logic [CNT_BITS-1:0] clamp_size(
		input logic [CNT_BITS-1:0] v,
		input logic [CNT_BITS-1:0] lim
	);
		if (v == '0) begin
			return CNT_BITS'(1);
		end
		return (v > lim) ? lim : v;
	endfunction

endpackage

// ===== design/tsmr_col_ram.sv =====
// Column sum store: one write port and one read port with registered read data.
module tsmr_col_ram
	import tsmr_pkg::*;
(
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [COL_BITS-1:0]        wr_addr,
	input  logic signed [ACC_BITS-1:0] wr_data,
	input  logic                       rd_en,
	input  logic [COL_BITS-1:0]        rd_addr,
	output logic signed [ACC_BITS-1:0] rd_data
);

	logic signed [ACC_BITS-1:0] mem_q [MAX_COLS];
	logic signed [ACC_BITS-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== design/tsmr_div.sv =====
// Iterative signed divider that truncates toward zero, one quotient bit per cycle.
module tsmr_div
	import tsmr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int STEP_BITS = $clog2(ACC_BITS);

	logic                      busy_q;
	logic                      done_q;
	logic                      neg_q;
	logic [ACC_BITS-1:0]       quo_q;
	logic [DIV_BITS-1:0]       rem_q;
	logic [DIV_BITS-1:0]       den_q;
	logic [STEP_BITS-1:0]      step_q;
	logic [DIV_BITS:0]         shifted;
	logic [DIV_BITS+1:0]       trial;
	logic                      borrow;

	// One restoring step: bring down the next dividend bit and try the subtraction.
	always_comb begin
		shifted = {rem_q, quo_q[ACC_BITS-1]};
		trial   = {1'b0, shifted} - {2'b00, den_q};
		borrow  = trial[DIV_BITS+1];
	end

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= STEP_BITS'(ACC_BITS - 1);
			end else if (busy_q) begin
				step_q <= step_q - STEP_BITS'(1);
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operands: the magnitude register turns into the quotient bit by bit.
	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.dividend[ACC_BITS-1];
			quo_q <= req.dividend[ACC_BITS-1] ? ACC_BITS'(-req.dividend) : req.dividend;
			rem_q <= '0;
			den_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[ACC_BITS-2:0], ~borrow};
			rem_q <= borrow ? shifted[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

// ===== design/tensor_sum_mean_reduction.sv =====
// Top level of the tensor sum and mean reduction block.
//
//  channel   signals                                       direction  handshake
//  sample    sample_valid, sample_stall, sample            in         valid / stall
//  result    result_valid, result_stall, value,            out        valid / stall
//            channel_index, column_index, last
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data     in         valid / ready
//
// Samples are taken one per cycle unless stalled: each is read from the column store
// at accept, added and written back from stage 1, forwarding when the same column
// comes back to back. A sample that ends a mean or column reduction holds the input
// while the sequencer delivers its results, a mean waiting on the one-bit-per-cycle
// divider. Reset needs no clearing pass; 64 valid bits mark the written columns. A
// four-deep result queue lets samples flow while results stall.
module tensor_sum_mean_reduction
	import tsmr_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	// Sample channel
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	// Result channel
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic signed [ACC_BITS-1:0]    value,
	output logic [CH_BITS-1:0]            channel_index,
	output logic [COL_BITS-1:0]           column_index,
	output logic                          last,
	// Configuration channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [CFG_DATA_BITS-1:0]      cfg_data
);

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = PTR_BITS + 1;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_READ = 5'b00010,
		S_DATA = 5'b00100,
		S_DIV  = 5'b01000,
		S_PUSH = 5'b10000
	} seq_state_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic [COL_BITS-1:0]           col;
		logic [CH_BITS-1:0]            ch;
		logic                          chan_start;
		logic                          clr_total;
		logic                          direct;
		logic                          seq;
	} s1_t;

	// Configuration registers
	logic [1:0]             mode_q;
	logic                   reduce_op_q;
	logic [CNT_BITS-1:0]    row_count_q;
	logic [COLCNT_BITS-1:0] col_count_q;
	logic [CNT_BITS-1:0]    channel_count_q;

	// Positions and accumulators
	logic [ROW_BITS-1:0]        row_pos_q;
	logic [COL_BITS-1:0]        col_pos_q;
	logic [CH_BITS-1:0]         ch_pos_q;
	logic signed [ACC_BITS-1:0] total_q;
	logic [MAX_COLS-1:0]        col_vld_q;
	logic                       last_wr_vld_q;
	logic [COL_BITS-1:0]        last_wr_col_q;
	logic signed [ACC_BITS-1:0] last_wr_data_q;

	// Divisors
	logic [RC_BITS-1:0]  rc_q;
	logic [DIV_BITS-1:0] all_q;

	// Pipeline and sequencer
	logic                       s1_vld_s1;
	s1_t                        s1_s1;
	logic                       busy_q;
	seq_state_t                 state_q;
	logic [CH_BITS-1:0]         seq_ch_q;
	logic [COL_BITS-1:0]        seq_col_q;
	logic signed [ACC_BITS-1:0] val_q;

	// Result queue
	result_t              fifo_q [FIFO_DEPTH];
	logic [PTR_BITS-1:0]  wr_ptr_q;
	logic [PTR_BITS-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]     fifo_cnt_q;

	// Combinational signals
	logic [CNT_BITS-1:0]        rows;
	logic [CNT_BITS-1:0]        chs;
	logic [COLCNT_BITS-1:0]     cols;
	logic [COL_BITS-1:0]        col_w;
	logic [ROW_BITS-1:0]        row_w;
	logic [CH_BITS-1:0]         ch_w;
	logic                       col_last;
	logic                       row_last;
	logic                       ch_last;
	logic                       chan_start;
	logic                       chan_end;
	logic                       tensor_end;
	logic                       accept;
	logic                       fwd_hit;
	logic signed [ACC_BITS-1:0] col_old;
	logic signed [ACC_BITS-1:0] col_new;
	logic signed [ACC_BITS-1:0] tot_new;
	logic signed [ACC_BITS-1:0] ram_rd_data;
	logic signed [ACC_BITS-1:0] col_rd_val;
	logic                       ram_rd_en;
	logic [COL_BITS-1:0]        ram_rd_addr;
	logic                       seq_col_last;
	logic                       s1_push;
	logic                       seq_push;
	logic                       pop;
	logic                       seq_start;
	result_t                    s1_res;
	result_t                    seq_res;
	result_t                    push_res;
	div_req_t                   div_req;
	div_rsp_t                   div_rsp;

	// Effective sizes of the tensor.
	assign rows = clamp_size(row_count_q, CNT_BITS'(MAX_ROWS));
	assign chs  = clamp_size(channel_count_q, CNT_BITS'(MAX_CHANNELS));
	assign cols = COLCNT_BITS'(clamp_size(CNT_BITS'(col_count_q), CNT_BITS'(MAX_COLS)));

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q          <= MODE_PASS;
			reduce_op_q     <= SUM;
			row_count_q     <= CNT_BITS'(1);
			col_count_q     <= COLCNT_BITS'(1);
			channel_count_q <= CNT_BITS'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MODE:          mode_q          <= cfg_data[1:0];
				REG_REDUCE_OP:     reduce_op_q     <= cfg_data[0];
				REG_ROW_COUNT:     row_count_q     <= cfg_data;
				REG_COL_COUNT:     col_count_q     <= cfg_data[COLCNT_BITS-1:0];
				REG_CHANNEL_COUNT: channel_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Mean divisors, refreshed every cycle from the settled sizes.
	always_ff @(posedge clk) begin
		rc_q  <= RC_BITS'(18'(rows) * 18'(cols));
		all_q <= DIV_BITS'(28'(rc_q) * 28'(chs));
	end

	// Stage 0: wrap the positions against the sizes and classify the sample.
	always_comb begin
		col_w      = ({1'b0, col_pos_q} >= cols) ? '0 : col_pos_q;
		row_w      = ({1'b0, row_pos_q} >= rows) ? '0 : row_pos_q;
		ch_w       = ({1'b0, ch_pos_q} >= chs) ? '0 : ch_pos_q;
		col_last   = ({1'b0, col_w} == cols - COLCNT_BITS'(1));
		row_last   = ({1'b0, row_w} == rows - CNT_BITS'(1));
		ch_last    = ({1'b0, ch_w} == chs - CNT_BITS'(1));
		chan_start = (row_w == '0) && (col_w == '0);
		chan_end   = col_last && row_last;
		tensor_end = chan_end && ch_last;
	end

	assign sample_stall = busy_q ||
		((fifo_cnt_q + CNT_W'(s1_vld_s1)) >= CNT_W'(FIFO_DEPTH - 1));
	assign accept = sample_valid && !sample_stall;

	// Position counters advance on every accepted sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_pos_q <= '0;
			col_pos_q <= '0;
			ch_pos_q  <= '0;
		end else if (accept) begin
			col_pos_q <= col_last ? '0 : col_w + COL_BITS'(1);
			row_pos_q <= row_w;
			ch_pos_q  <= ch_w;
			if (col_last) begin
				row_pos_q <= row_last ? '0 : row_w + ROW_BITS'(1);
				if (row_last) begin
					ch_pos_q <= ch_last ? '0 : ch_w + CH_BITS'(1);
				end
			end
		end
	end

	// Stage 1 register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_s1 <= 1'b0;
		end else begin
			s1_vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_s1.sample     <= sample;
			s1_s1.col        <= col_w;
			s1_s1.ch         <= ch_w;
			s1_s1.chan_start <= chan_start;
			s1_s1.clr_total  <= chan_start && ((mode_q == MODE_CHAN) || (ch_w == '0));
			s1_s1.direct     <= (mode_q == MODE_PASS) ||
				((mode_q == MODE_TENSOR) && tensor_end && (reduce_op_q == SUM)) ||
				((mode_q == MODE_CHAN) && chan_end && (reduce_op_q == SUM));
			s1_s1.seq        <= ((mode_q == MODE_TENSOR) && tensor_end && (reduce_op_q == MEAN)) ||
				((mode_q == MODE_CHAN) && chan_end && (reduce_op_q == MEAN)) ||
				((mode_q == MODE_COL) && chan_end);
		end
	end

	// Column store: the pipeline reads at accept, the sequencer while delivering.
	assign ram_rd_en   = accept || (state_q == S_READ);
	assign ram_rd_addr = accept ? col_w : seq_col_q;

	tsmr_col_ram u_col_ram (
		.clk     (clk),
		.wr_en   (s1_vld_s1),
		.wr_addr (s1_s1.col),
		.wr_data (col_new),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// Stage 1: read, modify, write back; a channel start sees every column as zero.
	always_comb begin
		fwd_hit = last_wr_vld_q && (last_wr_col_q == s1_s1.col);
		if (s1_s1.chan_start) begin
			col_old = '0;
		end else if (fwd_hit) begin
			col_old = last_wr_data_q;
		end else if (col_vld_q[s1_s1.col]) begin
			col_old = ram_rd_data;
		end else begin
			col_old = '0;
		end
		col_new = sat_add(col_old, s1_s1.sample);
		tot_new = sat_add(s1_s1.clr_total ? '0 : total_q, s1_s1.sample);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q       <= '0;
			col_vld_q     <= '0;
			last_wr_vld_q <= 1'b0;
		end else if (s1_vld_s1) begin
			total_q       <= tot_new;
			last_wr_vld_q <= 1'b1;
			if (s1_s1.chan_start) begin
				col_vld_q <= MAX_COLS'(1) << s1_s1.col;
			end else begin
				col_vld_q[s1_s1.col] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_vld_s1) begin
			last_wr_col_q  <= s1_s1.col;
			last_wr_data_q <= col_new;
		end
	end

	// Results that leave straight from stage 1.
	always_comb begin
		s1_push              = s1_vld_s1 && s1_s1.direct;
		s1_res.value         = (mode_q == MODE_PASS) ? ACC_BITS'(s1_s1.sample) : tot_new;
		s1_res.channel_index = (mode_q == MODE_TENSOR) ? '0 : s1_s1.ch;
		s1_res.column_index  = '0;
		s1_res.last          = 1'b1;
	end

	// Sequencer datapath.
	always_comb begin
		col_rd_val   = col_vld_q[seq_col_q] ? ram_rd_data : '0;
		seq_col_last = ({1'b0, seq_col_q} == cols - COLCNT_BITS'(1));
		seq_start    = s1_vld_s1 && s1_s1.seq;
		seq_push     = (state_q == S_PUSH) && (fifo_cnt_q != CNT_W'(FIFO_DEPTH));

		seq_res.value         = val_q;
		seq_res.channel_index = seq_ch_q;
		seq_res.column_index  = seq_col_q;
		seq_res.last          = (mode_q != MODE_COL) || seq_col_last;

		div_req.start    = (seq_start && (mode_q != MODE_COL)) ||
			((state_q == S_DATA) && (reduce_op_q == MEAN));
		div_req.dividend = (state_q == S_DATA) ? col_rd_val : tot_new;
		unique case (mode_q)
			MODE_COL:  div_req.divisor = DIV_BITS'(rows);
			MODE_CHAN: div_req.divisor = DIV_BITS'(rc_q);
			default:   div_req.divisor = all_q;
		endcase
	end

	tsmr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Sequencer: delivers the reduction results, holding the input meanwhile.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			if (accept && (((mode_q == MODE_TENSOR) && tensor_end && (reduce_op_q == MEAN)) ||
				((mode_q == MODE_CHAN) && chan_end && (reduce_op_q == MEAN)) ||
				((mode_q == MODE_COL) && chan_end))) begin
				busy_q <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (seq_start) begin
						state_q <= (mode_q == MODE_COL) ? S_READ : S_DIV;
					end
				end
				S_READ: state_q <= S_DATA;
				S_DATA: state_q <= (reduce_op_q == MEAN) ? S_DIV : S_PUSH;
				S_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (seq_push) begin
						if ((mode_q == MODE_COL) && !seq_col_last) begin
							state_q <= S_READ;
						end else begin
							state_q <= S_IDLE;
							busy_q  <= 1'b0;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && seq_start) begin
			seq_ch_q  <= (mode_q == MODE_TENSOR) ? '0 : s1_s1.ch;
			seq_col_q <= '0;
		end else if (seq_push && (mode_q == MODE_COL) && !seq_col_last) begin
			seq_col_q <= seq_col_q + COL_BITS'(1);
		end
		if ((state_q == S_DATA) && (reduce_op_q == SUM)) begin
			val_q <= col_rd_val;
		end else if ((state_q == S_DIV) && div_rsp.done) begin
			val_q <= div_rsp.quotient;
		end
	end

	// Result queue.
	assign pop      = result_valid && !result_stall;
	assign push_res = seq_push ? seq_res : s1_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
		end else begin
			if (s1_push || seq_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
			end
			fifo_cnt_q <= fifo_cnt_q + CNT_W'(s1_push || seq_push) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_push || seq_push) begin
			fifo_q[wr_ptr_q] <= push_res;
		end
	end

	assign result_valid  = (fifo_cnt_q != '0);
	assign value         = fifo_q[rd_ptr_q].value;
	assign channel_index = fifo_q[rd_ptr_q].channel_index;
	assign column_index  = fifo_q[rd_ptr_q].column_index;
	assign last          = fifo_q[rd_ptr_q].last;

	// The queue never takes a request while it is full.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_push || seq_push) |-> (fifo_cnt_q != CNT_W'(FIFO_DEPTH)))
		else $error("result queue overflow");

	// Stage 1 and the sequencer never deliver in the same cycle.
	assert property (@(posedge clk) disable iff (!arst_n) !(s1_push && seq_push))
		else $error("two results pushed in one cycle");

	// The sequencer only runs while the input is held.
	assert property (@(posedge clk) disable iff (!arst_n) (state_q != S_IDLE) |-> busy_q)
		else $error("sequencer active while samples are taken");

	// The divider is never restarted while it is working.
	assert property (@(posedge clk) disable iff (!arst_n) div_req.start |-> !div_rsp.busy)
		else $error("divider restarted while busy");

	// A sample that ends a mean or column reduction stops the input on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_vld_s1 && s1_s1.seq) |-> sample_stall)
		else $error("input not held during result delivery");

endmodule
